/* hw/rtl/fotp_pkg.sv */
package fotp_pkg;

    // event kinds on the result channel
    localparam logic [2:0] EV_KEY_BYTE   = 3'd0;
    localparam logic [2:0] EV_KEY_COMMIT = 3'd1;
    localparam logic [2:0] EV_VAL_BYTE   = 3'd2;
    localparam logic [2:0] EV_VAL_DONE   = 3'd3;
    localparam logic [2:0] EV_NUMBER     = 3'd4;
    localparam logic [2:0] EV_PARSE_END  = 3'd5;

    // characters the parser reacts to
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;

    // largest magnitude that may still take another digit (2^63 / 10)
    localparam logic [63:0] MAG_LIMIT = 64'd922337203685477580;

    // event queue geometry
    localparam int QDEPTH = 8;
    localparam int QPTR_W = 3;
    localparam int QCNT_W = 4;
    localparam int EV_PER_BYTE = 3;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         ch;
        logic signed [63:0] val;
        logic               last;
    } fotp_ev_t;

    // events produced by one byte, written to the queue together
    typedef struct packed {
        logic [1:0]          cnt;
        fotp_ev_t [2:0]      ev;
    } fotp_push_t;

    function automatic fotp_ev_t mk_ev(input logic [2:0] kind, input logic [7:0] ch,
                                       input logic [63:0] val);
        fotp_ev_t e;
        e.kind = kind;
        e.ch   = ch;
        e.val  = val;
        e.last = 1'b0;
        return e;
    endfunction

    function automatic logic [7:0] esc_decode(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            CH_LC_B: r = 8'd8;
            CH_LC_F: r = 8'd12;
            CH_LC_N: r = 8'd10;
            CH_LC_R: r = 8'd13;
            CH_LC_T: r = 8'd9;
            default: r = e;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/fotp_parse.sv */
module fotp_parse (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [7:0]         text_byte,
    input  logic               final_byte,
    output fotp_pkg::fotp_push_t push
);
    import fotp_pkg::*;

    typedef enum logic [3:0] {
        PH_OPEN     = 4'd0,
        PH_KEYWAIT  = 4'd1,
        PH_INKEY    = 4'd2,
        PH_KEYESC   = 4'd3,
        PH_AFTERKEY = 4'd4,
        PH_VALWAIT  = 4'd5,
        PH_INVAL    = 4'd6,
        PH_VALESC   = 4'd7,
        PH_NUM      = 4'd8,
        PH_AFTERVAL = 4'd9,
        PH_DONE     = 4'd10
    } phase_t;

    phase_t      phase_reg, phase_next, phase_h;
    logic [63:0] mag_reg, mag_next;
    logic [63:0] nacc_reg, nacc_next;   // running negated magnitude
    logic        neg_reg, neg_next;
    logic        seen_reg, seen_next;
    logic        exc_reg, exc_next;

    logic        is_ws, is_dig, is_sign;
    logic [63:0] dig, dig_mag, dig_nacc, numv;
    logic        over;
    phase_t      av_phase, kw_phase;
    logic        av_commit, av_fin, kw_commit, kw_fin;
    logic        a0_num;
    fotp_ev_t    cand [6];
    logic [5:0]  cv;
    fotp_ev_t [2:0] slot;
    logic [1:0]  cnt;

    always_comb begin
        is_ws   = (text_byte inside {8'd32, [8'd9:8'd13]});
        is_dig  = (text_byte inside {[8'd48:8'd57]});
        is_sign = (text_byte == CH_MINUS) || (text_byte == CH_PLUS);
        dig     = {60'd0, text_byte[3:0]};

        // one decimal step, magnitude and its negation side by side
        dig_mag  = (mag_reg << 3) + (mag_reg << 1) + dig;
        dig_nacc = (nacc_reg << 3) + (nacc_reg << 1) - dig;
        over     = (mag_reg > MAG_LIMIT) || ((mag_reg == MAG_LIMIT) && (text_byte[3:0] > 4'd8));

        // key expected
        kw_phase  = PH_DONE;
        kw_commit = 1'b0;
        kw_fin    = 1'b0;
        if (text_byte == CH_QUOTE) begin
            kw_phase = PH_INKEY;
        end else if (text_byte == CH_COLON) begin
            kw_phase  = PH_VALWAIT;
            kw_commit = 1'b1;
        end else begin
            kw_fin = 1'b1;
        end

        // byte after a value
        av_phase  = kw_phase;
        av_commit = kw_commit;
        av_fin    = kw_fin;
        if (is_ws) begin
            av_phase  = PH_AFTERVAL;
            av_commit = 1'b0;
            av_fin    = 1'b0;
        end else if (text_byte == CH_COMMA) begin
            av_phase  = PH_KEYWAIT;
            av_commit = 1'b0;
            av_fin    = 1'b0;
        end else if (text_byte == CH_RBRACE) begin
            av_commit = 1'b0;
            av_fin    = 1'b1;
        end

        phase_h   = phase_reg;
        mag_next  = mag_reg;
        nacc_next = nacc_reg;
        neg_next  = neg_reg;
        seen_next = seen_reg;
        exc_next  = exc_reg;
        a0_num    = 1'b0;
        cv        = '0;
        for (int i = 0; i < 6; i++) begin
            cand[i] = '0;
        end

        case (phase_reg)
            PH_OPEN: begin
                if (!is_ws) begin
                    if (text_byte == CH_LBRACE) phase_h = PH_KEYWAIT;
                    else cv[2] = 1'b1;
                end
            end
            PH_KEYWAIT: begin
                if (!is_ws) begin
                    if (text_byte == CH_RBRACE) begin
                        cv[2] = 1'b1;
                    end else begin
                        phase_h = kw_phase;
                        cv[0]   = kw_commit;
                        cand[0] = mk_ev(EV_KEY_COMMIT, 8'd0, 64'd0);
                        cv[2]   = kw_fin;
                    end
                end
            end
            PH_INKEY: begin
                if (text_byte == CH_QUOTE) begin
                    phase_h = PH_AFTERKEY;
                end else if (text_byte == CH_BSLASH) begin
                    phase_h = PH_KEYESC;
                end else begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_ev(EV_KEY_BYTE, text_byte, 64'd0);
                end
            end
            PH_KEYESC: begin
                cv[0]   = 1'b1;
                cand[0] = mk_ev(EV_KEY_BYTE, esc_decode(text_byte), 64'd0);
                phase_h = PH_INKEY;
            end
            PH_AFTERKEY: begin
                if (!is_ws) begin
                    if (text_byte == CH_COLON) begin
                        cv[0]   = 1'b1;
                        cand[0] = mk_ev(EV_KEY_COMMIT, 8'd0, 64'd0);
                        phase_h = PH_VALWAIT;
                    end else begin
                        cv[2] = 1'b1;
                    end
                end
            end
            PH_VALWAIT: begin
                if (!is_ws) begin
                    if (text_byte == CH_QUOTE) begin
                        phase_h = PH_INVAL;
                    end else if (is_sign || is_dig) begin
                        // first digit of a fresh number is the digit itself
                        mag_next  = is_dig ? dig : 64'd0;
                        nacc_next = is_dig ? (64'd0 - dig) : 64'd0;
                        neg_next  = (text_byte == CH_MINUS);
                        seen_next = is_dig;
                        exc_next  = 1'b0;
                        phase_h   = PH_NUM;
                    end else begin
                        phase_h = av_phase;
                        cv[0]   = av_commit;
                        cand[0] = mk_ev(EV_KEY_COMMIT, 8'd0, 64'd0);
                        cv[2]   = av_fin;
                    end
                end
            end
            PH_INVAL: begin
                if (text_byte == CH_QUOTE) begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_ev(EV_VAL_DONE, 8'd0, 64'd0);
                    phase_h = PH_AFTERVAL;
                end else if (text_byte == CH_BSLASH) begin
                    phase_h = PH_VALESC;
                end else begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_ev(EV_VAL_BYTE, text_byte, 64'd0);
                end
            end
            PH_VALESC: begin
                cv[0]   = 1'b1;
                cand[0] = mk_ev(EV_VAL_BYTE, esc_decode(text_byte), 64'd0);
                phase_h = PH_INVAL;
            end
            PH_NUM: begin
                if (is_dig) begin
                    seen_next = 1'b1;
                    if (!exc_reg) begin
                        if (over) begin
                            exc_next = 1'b1;
                        end else begin
                            mag_next  = dig_mag;
                            nacc_next = dig_nacc;
                        end
                    end
                end else begin
                    cv[0]   = 1'b1;
                    a0_num  = 1'b1;
                    phase_h = av_phase;
                    cv[1]   = av_commit;
                    cand[1] = mk_ev(EV_KEY_COMMIT, 8'd0, 64'd0);
                    cv[2]   = av_fin;
                end
            end
            PH_AFTERVAL: begin
                phase_h = av_phase;
                cv[0]   = av_commit;
                cand[0] = mk_ev(EV_KEY_COMMIT, 8'd0, 64'd0);
                cv[2]   = av_fin;
            end
            default: begin
                // ended: ignore bytes until the final one
            end
        endcase

        if (cv[2]) begin
            phase_h = PH_DONE;
        end
        cand[2] = mk_ev(EV_PARSE_END, 8'd0, 64'd0);

        // number value after this byte's digit, if any
        if (!seen_next || exc_next) numv = 64'd0;
        else if (neg_next) numv = nacc_next;
        else if (mag_next[63]) numv = 64'd0;
        else numv = mag_next;

        if (a0_num) begin
            cand[0] = mk_ev(EV_NUMBER, 8'd0, numv);
        end

        // close whatever is open at the end of the text
        cand[5] = mk_ev(EV_PARSE_END, 8'd0, 64'd0);
        if (final_byte && (phase_h < PH_DONE)) begin
            cv[5] = 1'b1;
            case (phase_h)
                PH_KEYESC: begin
                    cv[3]   = 1'b1;
                    cand[3] = mk_ev(EV_KEY_BYTE, CH_BSLASH, 64'd0);
                end
                PH_VALESC: begin
                    cv[3]   = 1'b1;
                    cand[3] = mk_ev(EV_VAL_BYTE, CH_BSLASH, 64'd0);
                    cv[4]   = 1'b1;
                    cand[4] = mk_ev(EV_VAL_DONE, 8'd0, 64'd0);
                end
                PH_INVAL: begin
                    cv[3]   = 1'b1;
                    cand[3] = mk_ev(EV_VAL_DONE, 8'd0, 64'd0);
                end
                PH_NUM: begin
                    cv[3]   = 1'b1;
                    cand[3] = mk_ev(EV_NUMBER, 8'd0, numv);
                end
                default: begin
                end
            endcase
        end

        phase_next = phase_h;
        if (final_byte) begin
            phase_next = PH_OPEN;
            mag_next   = 64'd0;
            nacc_next  = 64'd0;
            neg_next   = 1'b0;
            seen_next  = 1'b0;
            exc_next   = 1'b0;
        end

        // pack the valid candidates into the first slots
        slot = '0;
        cnt  = 2'd0;
        for (int i = 0; i < 6; i++) begin
            if (cv[i] && (cnt != 2'd3)) begin
                slot[cnt] = cand[i];
                cnt       = cnt + 2'd1;
            end
        end
        case (cnt)
            2'd1:    slot[0].last = 1'b1;
            2'd2:    slot[1].last = 1'b1;
            2'd3:    slot[2].last = 1'b1;
            default: begin
            end
        endcase

        push.cnt = step ? cnt : 2'd0;
        push.ev  = slot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPEN;
            mag_reg   <= '0;
            nacc_reg  <= '0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            exc_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            nacc_reg  <= nacc_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            exc_reg   <= exc_next;
        end
    end

endmodule

/* hw/rtl/fotp_evq.sv */
module fotp_evq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fotp_pkg::fotp_push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fotp_pkg::fotp_ev_t   head
);
    import fotp_pkg::*;

    fotp_ev_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                pop;

    assign out_valid = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // space for a whole byte's worth of events
    assign room      = (cnt_reg <= QCNT_W'(QDEPTH - EV_PER_BYTE));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + QCNT_W'(push.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < EV_PER_BYTE; i++) begin
            if (2'(i) < push.cnt) begin
                mem_reg[wr_ptr_reg + QPTR_W'(i)] <= push.ev[i];
            end
        end
    end

endmodule

/* hw/rtl/flat_object_text_parser_unit.sv */
// flat object text parser
//
// s_ channel: one text byte per item, s_tlast marks the last byte of a text.
// m_ channel: one parse event per item; m_tlast flags the last event that a
// given input byte produced. event kinds: key byte, key committed, value
// byte, value done, number, parse end. char and number fields are zero when
// the kind does not use them.
// pipeline: an input register feeds the parser, which writes 0 to 3 events
// per byte into an 8-entry event queue; the queue head drives m_.
// an accepted byte is held in the input register, where the parser decodes
// it; its events are then registered into the queue, and m_ takes them from
// the queue head. throughput: one byte per cycle while the queue has room
// for three events; the queue drains one event per cycle, so a long run of
// bytes that each make several events is paced by the m_ side.
// a stall on m_ only fills the queue; s_tready drops once the queue can no
// longer take a full byte's events and the held byte waits in the input
// register.
// reset (aresetn low, synchronous) empties the queue and the input register
// and puts the parser back to waiting for an opening brace.
module flat_object_text_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,    // final_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [2:0] event_kind, [10:3] char_out,
                                    // [74:11] int_value, [79:75] zero
    output logic        m_tlast     // run_end
);
    import fotp_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       room;
    logic       advance;
    fotp_push_t push;
    fotp_ev_t   head;

    // the held byte moves on when the queue can take all its events
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    fotp_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .text_byte  (in_byte_reg),
        .final_byte (in_last_reg),
        .push       (push)
    );

    fotp_evq u_evq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    // result item packing, lowest field first
    assign m_tdata = {5'd0, head.val, head.ch, head.kind};
    assign m_tlast = head.last;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import fotp_pkg::*;

    // bytes with a meaning for the parser that the package does not name
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // control codes that the escapes b f n r t stand for
    localparam logic [7:0] CC_BACKSPACE = 8'd8;
    localparam logic [7:0] CC_FORMFEED  = 8'd12;
    localparam logic [7:0] CC_NEWLINE   = 8'd10;
    localparam logic [7:0] CC_RETURN    = 8'd13;
    localparam logic [7:0] CC_TAB       = 8'd9;

    localparam int RANDOM_BYTES   = 16;
    localparam int STALL_DIGITS   = 10;   // enough events to fill the queue
    localparam int STALL_CYCLES   = 80;   // long hold-off on the result side
    localparam int TAIL_CYCLES    = 20;   // quiet time after the last event
    localparam int WATCHDOG_LIMIT = 1000; // cycles with no handshake at all
    localparam int MAX_REPORTS    = 40;

    typedef enum logic [3:0] {
        SEEK_OPEN, KEY_WAIT, IN_KEY, KEY_ESC, AFTER_KEY, VAL_WAIT,
        IN_VAL, VAL_ESC, IN_NUM, AFTER_VAL, PARSE_OVER
    } parse_phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] text_byte
    logic        s_tlast;     // final_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;     // [2:0] event_kind, [10:3] char_out, [74:11] int_value
    logic        m_tlast;     // run_end

    flat_object_text_parser_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // parser state as the testbench sees it
    parse_phase_t phase;
    logic [63:0]  num_mag;
    logic         num_neg;
    logic         num_has_digit;
    logic         num_overflow;

    fotp_ev_t byte_events[$];     // events of the byte being predicted
    fotp_ev_t expected_events[$]; // events still owed by the block
    logic [7:0] text_bytes[$];    // text about to be sent

    int  mismatches    = 0;
    int  bytes_sent    = 0;
    int  idle_cycles   = 0;
    int  rx_hold_cycles = 0;
    bit  tx_idle_on    = 1'b1;
    bit  rx_idle_on    = 1'b1;

    // ------------------------------------------------------------------
    // event prediction
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        phase         = SEEK_OPEN;
        num_mag       = '0;
        num_neg       = 1'b0;
        num_has_digit = 1'b0;
        num_overflow  = 1'b0;
    endfunction

    // at most three events come from one byte, extra ones are dropped
    function automatic void add_event(input logic [2:0] kind, input logic [7:0] ch,
                                      input logic [63:0] val);
        fotp_ev_t e;
        if (byte_events.size() >= EV_PER_BYTE)
            return;
        e.kind = kind;
        e.ch   = ch;
        e.val  = val;
        e.last = 1'b0;
        byte_events = {byte_events, e};
    endfunction

    // append one byte to the text being built
    function automatic void add_text_byte(input logic [7:0] c);
        text_bytes = {text_bytes, c};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            CH_LC_B: return CC_BACKSPACE;
            CH_LC_F: return CC_FORMFEED;
            CH_LC_N: return CC_NEWLINE;
            CH_LC_R: return CC_RETURN;
            CH_LC_T: return CC_TAB;
            default: return c;
        endcase
    endfunction

    function automatic void end_parse();
        add_event(EV_PARSE_END, 8'd0, 64'd0);
        phase = PARSE_OVER;
    endfunction

    // zero for a bare sign or anything outside the signed 64-bit range
    function automatic logic [63:0] number_value();
        if (!num_has_digit || num_overflow)
            return 64'd0;
        if (num_neg)
            return 64'd0 - num_mag;
        if (num_mag[63])
            return 64'd0;
        return num_mag;
    endfunction

    function automatic void key_start(input logic [7:0] c);
        if (c == CH_QUOTE) begin
            phase = IN_KEY;
        end else if (c == CH_COLON) begin
            add_event(EV_KEY_COMMIT, 8'd0, 64'd0);
            phase = VAL_WAIT;
        end else begin
            end_parse();
        end
    endfunction

    function automatic void after_value(input logic [7:0] c);
        if (is_blank(c))
            phase = AFTER_VAL;
        else if (c == CH_COMMA)
            phase = KEY_WAIT;
        else if (c == CH_RBRACE)
            end_parse();
        else
            key_start(c);
    endfunction

    // magnitude stops growing once it would pass 2^63
    function automatic void take_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        num_has_digit = 1'b1;
        if (num_overflow)
            return;
        if (num_mag > MAG_LIMIT || (num_mag == MAG_LIMIT && d > 64'd8))
            num_overflow = 1'b1;
        else
            num_mag = num_mag * 64'd10 + d;
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        case (phase)
            SEEK_OPEN: begin
                if (!is_blank(c)) begin
                    if (c == CH_LBRACE) phase = KEY_WAIT;
                    else end_parse();
                end
            end
            KEY_WAIT: begin
                if (!is_blank(c)) begin
                    if (c == CH_RBRACE) end_parse();
                    else key_start(c);
                end
            end
            IN_KEY: begin
                if (c == CH_QUOTE) phase = AFTER_KEY;
                else if (c == CH_BSLASH) phase = KEY_ESC;
                else add_event(EV_KEY_BYTE, c, 64'd0);
            end
            KEY_ESC: begin
                add_event(EV_KEY_BYTE, unescape(c), 64'd0);
                phase = IN_KEY;
            end
            AFTER_KEY: begin
                if (!is_blank(c)) begin
                    if (c == CH_COLON) begin
                        add_event(EV_KEY_COMMIT, 8'd0, 64'd0);
                        phase = VAL_WAIT;
                    end else begin
                        end_parse();
                    end
                end
            end
            VAL_WAIT: begin
                if (is_blank(c)) begin
                    // stay
                end else if (c == CH_QUOTE) begin
                    phase = IN_VAL;
                end else if (c == CH_MINUS || c == CH_PLUS || is_digit(c)) begin
                    num_mag       = '0;
                    num_neg       = (c == CH_MINUS);
                    num_has_digit = 1'b0;
                    num_overflow  = 1'b0;
                    if (is_digit(c)) take_digit(c);
                    phase = IN_NUM;
                end else begin
                    // nothing that starts a value: treat as the byte after one
                    after_value(c);
                end
            end
            IN_VAL: begin
                if (c == CH_QUOTE) begin
                    add_event(EV_VAL_DONE, 8'd0, 64'd0);
                    phase = AFTER_VAL;
                end else if (c == CH_BSLASH) begin
                    phase = VAL_ESC;
                end else begin
                    add_event(EV_VAL_BYTE, c, 64'd0);
                end
            end
            VAL_ESC: begin
                add_event(EV_VAL_BYTE, unescape(c), 64'd0);
                phase = IN_VAL;
            end
            IN_NUM: begin
                if (is_digit(c)) begin
                    take_digit(c);
                end else begin
                    add_event(EV_NUMBER, 8'd0, number_value());
                    after_value(c);
                end
            end
            AFTER_VAL: after_value(c);
            default: ; // parse over: ignore until the final byte
        endcase
    endfunction

    function automatic void predict_byte(input logic [7:0] c, input logic final_byte);
        byte_events.delete();
        parse_byte(c);
        if (final_byte) begin
            // close whatever is still open, then end the parse
            if (phase != PARSE_OVER) begin
                case (phase)
                    KEY_ESC: add_event(EV_KEY_BYTE, CH_BSLASH, 64'd0);
                    VAL_ESC: begin
                        add_event(EV_VAL_BYTE, CH_BSLASH, 64'd0);
                        add_event(EV_VAL_DONE, 8'd0, 64'd0);
                    end
                    IN_VAL:  add_event(EV_VAL_DONE, 8'd0, 64'd0);
                    IN_NUM:  add_event(EV_NUMBER, 8'd0, number_value());
                    default: ;
                endcase
                add_event(EV_PARSE_END, 8'd0, 64'd0);
            end
            clear_parser();
        end
        if (byte_events.size() > 0)
            byte_events[byte_events.size() - 1].last = 1'b1;
        expected_events = {expected_events, byte_events};
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    always @(posedge aclk) begin : check_events
        fotp_ev_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event kind %0d", m_tdata[2:0]));
            end else begin
                want = expected_events.pop_front();
                if (m_tdata[2:0] !== want.kind)
                    report_mismatch($sformatf("event kind %0d, want %0d",
                                              m_tdata[2:0], want.kind));
                if (m_tdata[10:3] !== want.ch)
                    report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                              m_tdata[10:3], want.ch));
                if (m_tdata[74:11] !== want.val)
                    report_mismatch($sformatf("number %0d, want %0d",
                                              $signed(m_tdata[74:11]), want.val));
                if (m_tdata[79:75] !== 5'd0)
                    report_mismatch($sformatf("pad bits 0x%02h not zero", m_tdata[79:75]));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("run end %0b, want %0b", m_tlast, want.last));
            end
        end
    end

    // no handshake on either side for too long means the block is stuck
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("flat_object_text_parser_unit: mismatch");
                $finish;
            end
        end
    end

    // result side: random stall per event, plus a long hold-off on request
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            stall = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // offer one byte after a random gap, predict it once accepted
    task automatic send_byte(input logic [7:0] c, input logic final_byte);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= final_byte;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_byte(c, final_byte);
        bytes_sent++;
    endtask

    // sends text_bytes as one text, final flag on its last byte
    task automatic send_text();
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic send_string(input string s);
        text_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            add_text_byte(s[i]);
        send_text();
    endtask

    // input stops until every owed event has come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_events.size() != 0);
    endtask

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic void append_blanks();
        repeat ($urandom_range(0, 2))
            add_text_byte(any_blank());
    endfunction

    // quoted key or string value, any byte inside, some escapes
    function automatic void append_quoted(input int max_len);
        logic [7:0] c;
        add_text_byte(CH_QUOTE);
        repeat ($urandom_range(0, max_len)) begin
            if ($urandom_range(0, 4) == 0) begin
                add_text_byte(CH_BSLASH);
                case ($urandom_range(0, 6))
                    0: add_text_byte(CH_LC_B);
                    1: add_text_byte(CH_LC_F);
                    2: add_text_byte(CH_LC_N);
                    3: add_text_byte(CH_LC_R);
                    4: add_text_byte(CH_LC_T);
                    default: add_text_byte(8'($urandom_range(0, 255)));
                endcase
            end else begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
                add_text_byte(c);
            end
        end
        add_text_byte(CH_QUOTE);
    endfunction

    // mostly well-formed objects with random content, some cut short or noisy
    function automatic void build_random_text();
        int mode;
        int sign;
        int ndig;
        mode = $urandom_range(0, 9);
        text_bytes.delete();
        if (mode == 8) begin
            repeat ($urandom_range(1, 6))
                add_text_byte(8'($urandom_range(0, 255)));
            return;
        end
        append_blanks();
        add_text_byte(CH_LBRACE);
        repeat ($urandom_range(0, 3)) begin
            append_blanks();
            if ($urandom_range(0, 4) != 0) begin
                append_quoted(4);
                append_blanks();
            end
            add_text_byte(CH_COLON);
            append_blanks();
            case ($urandom_range(0, 4))
                0, 1: append_quoted(6);
                2, 3: begin
                    sign = $urandom_range(0, 2);
                    ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 21)
                                                       : $urandom_range(0, 6);
                    if (sign == 0 && ndig == 0) ndig = 1;
                    if (sign == 1) add_text_byte(CH_MINUS);
                    if (sign == 2) add_text_byte(CH_PLUS);
                    repeat (ndig)
                        add_text_byte(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                default: ; // missing value
            endcase
            case ($urandom_range(0, 2))
                0: add_text_byte(CH_COMMA);
                1: append_blanks();
                default: ;
            endcase
        end
        if ($urandom_range(0, 3) != 0)
            add_text_byte(CH_RBRACE);
        if (mode == 9) begin
            // bytes after the end that the parser must ignore
            repeat ($urandom_range(1, 3))
                add_text_byte(8'($urandom_range(0, 255)));
        end
        if (mode == 7) begin
            // text cut short somewhere inside
            ndig = $urandom_range(1, text_bytes.size());
            while (text_bytes.size() > ndig)
                void'(text_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // pairs, escapes of every kind, optional commas, a signed number
    task automatic test_pairs_and_escapes();
        send_string("{\"ab\":\"x\\n\\q\" ,\"\\b\\f\":\"\\r\\t\\\"\"\"k\":+7}");
        wait_drain();
    endtask

    // largest and smallest numbers, one past each, bare signs
    task automatic test_number_range();
        send_string("{:9223372036854775807,:-9223372036854775808 :9223372036854775808");
        send_string("{:-9223372036854775809,:-,:+}");
        wait_drain();
    endtask

    // texts that end in every open state, missing values, stray bytes
    task automatic test_text_endings();
        send_string("{\"k\\");
        send_string("{:\"v\\");
        send_string("{:\"v");
        send_string("{:-42");
        send_string("{\"k\":x");
        send_string("{:,}");
        send_string("{:}");
        send_string("x{\"a\"}");
        send_string("{");
        send_string("{}");
        wait_drain();
    endtask

    // every blank byte and the byte extremes inside strings
    task automatic test_blanks_and_byte_extremes();
        text_bytes = {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_LBRACE, CH_TAB,
                      CH_QUOTE, 8'hFF, 8'h00, CH_QUOTE, CH_VT, CH_COLON, CH_FF,
                      CH_QUOTE, 8'h80, 8'h7F, CH_QUOTE, CH_CR, CH_RBRACE};
        send_text();
        wait_drain();
    endtask

    // result side held off while a long string fills the event queue
    task automatic test_stalled_output();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = STALL_CYCLES;
        text_bytes     = {CH_LBRACE, CH_QUOTE, CH_LC_N, CH_QUOTE, CH_COLON, CH_QUOTE};
        repeat (STALL_DIGITS)
            add_text_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        add_text_byte(CH_QUOTE);
        add_text_byte(CH_RBRACE);
        send_text();
        wait_drain();
        tx_idle_on = 1'b1;
    endtask

    // both sides at full rate, no gaps at all
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (2) begin
            build_random_text();
            send_text();
        end
        wait_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_texts();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            build_random_text();
            send_text();
            // now and then let the whole pipe run empty
            if ($urandom_range(0, 7) == 0)
                wait_drain();
        end
        wait_drain();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tlast  <= 1'b0;
        clear_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_pairs_and_escapes();
        test_number_range();
        test_text_endings();
        test_blanks_and_byte_extremes();
        test_stalled_output();
        test_full_rate();
        test_random_texts();

        // a trailing byte may still be inside the block with no event to show
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d events never came", expected_events.size()));

        if (mismatches == 0)
            $display("flat_object_text_parser_unit: match");
        else
            $display("flat_object_text_parser_unit: mismatch");
        $finish;
    end

endmodule
